[rtl/isc_pkg.sv]
// Shared constants and types for the interval stabbing counter.
`timescale 1ns / 1ps
package isc_pkg;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CountW   = 11;
  localparam logic [CountW-1:0] CountMax = '1;
endpackage

[rtl/isc_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module isc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end
endmodule

[rtl/interval_stabbing_count.sv]
// Interval stabbing counter: loads intervals into a RAM, bubble-sorts them, counts groups.
`timescale 1ns / 1ps
// Intervals arrive one beat per cycle and are written into a single RAM of
// MAX_INTERVALS entries; beats past that are dropped and flagged. The beat
// with tlast starts the computation: bubble-sort passes over the RAM (up to
// n-1 passes, stopping early after a pass with no swap), then one scan.
// Sorting and scanning run on the one read and one write port of that RAM.
// While they run, s_axis_tready is low. The result beat is held until taken;
// loading of the next set may proceed meanwhile, its last beat waits.
module interval_stabbing_count import isc_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = 1024,
  parameter int unsigned COORD_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // span_start[31:0], span_end[63:32]
  input  logic                s_axis_tuser,   // carries_interval
  input  logic                s_axis_tlast,   // last_of_set
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // point_count[10:0], zeros above
  output logic                m_axis_tuser    // overflowed
);
  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned EW = 2 * COORD_BITS;

  typedef enum logic [3:0] {
    StLoad, StPStart, StPFirst, StPCmp, StPTail,
    StSStart, StSFirst, StSStep, StDone
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] lim_q, lim_d;
  logic [AW-1:0] j_q, j_d;
  logic [EW-1:0] cur_q, cur_d;
  logic          swp_q, swp_d;
  logic          ovf_q, ovf_d;
  logic [COORD_BITS-1:0] min_q, min_d;
  logic [CW-1:0] grp_q, grp_d;
  logic          mval_q, mval_d;
  logic [CountW-1:0] mcnt_q, mcnt_d;
  logic          movf_q, movf_d;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;
  logic          in_acc;

  isc_ram #(.Width(EW), .Depth(MAX_INTERVALS)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // a strictly before b: by start, then by end (signed)
  function automatic logic span_precedes(logic [EW-1:0] a, logic [EW-1:0] b);
    logic signed [COORD_BITS-1:0] alo, ahi, blo, bhi;
    alo = a[COORD_BITS-1:0];
    ahi = a[EW-1:COORD_BITS];
    blo = b[COORD_BITS-1:0];
    bhi = b[EW-1:COORD_BITS];
    if (alo != blo) return alo < blo;
    return ahi < bhi;
  endfunction

  logic signed [COORD_BITS-1:0] x_lo, x_hi, min_s;
  logic [31:0] grp_ext;
  assign x_lo    = rd_data[COORD_BITS-1:0];
  assign x_hi    = rd_data[EW-1:COORD_BITS];
  assign min_s   = min_q;
  assign grp_ext = 32'(grp_q);

  assign s_axis_tready = (state_q == StLoad) && (!mval_q || !s_axis_tlast);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    n_d = n_q; lim_d = lim_q; j_d = j_q; cur_d = cur_q; swp_d = swp_q;
    ovf_d = ovf_q; min_d = min_q; grp_d = grp_q;
    mval_d = mval_q; mcnt_d = mcnt_q; movf_d = movf_q;
    wr_en = 1'b0;
    wr_addr = j_q - AW'(1);
    wr_data = cur_q;
    rd_addr = '0;
    if (mval_q && m_axis_tready) mval_d = 1'b0;
    unique case (state_q)
      StLoad: begin
        wr_addr = n_q[AW-1:0];
        wr_data = {s_axis_tdata[32 +: COORD_BITS], s_axis_tdata[0 +: COORD_BITS]};
        if (in_acc) begin
          if (s_axis_tuser) begin
            if (n_q < CW'(MAX_INTERVALS)) begin
              wr_en = 1'b1;
              n_d = n_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (s_axis_tlast) begin
            lim_d = n_d;
            swp_d = 1'b0;
            state_d = (n_d < CW'(2)) ? StSStart : StPStart;
          end
        end
      end
      StPStart: begin
        rd_addr = '0;
        swp_d = 1'b0;
        state_d = StPFirst;
      end
      StPFirst: begin
        rd_addr = AW'(1);
        cur_d = rd_data;
        j_d = AW'(1);
        state_d = StPCmp;
      end
      StPCmp: begin
        rd_addr = j_q + AW'(1);
        wr_en = 1'b1;
        if (span_precedes(rd_data, cur_q)) begin
          wr_data = rd_data;
          swp_d = 1'b1;
        end else begin
          wr_data = cur_q;
          cur_d = rd_data;
        end
        if (CW'(j_q) == lim_q - CW'(1)) state_d = StPTail;
        else j_d = j_q + AW'(1);
      end
      StPTail: begin
        // park the pass maximum at the end of the shrinking range
        wr_en = 1'b1;
        wr_addr = j_q;
        wr_data = cur_q;
        lim_d = lim_q - CW'(1);
        if (!swp_q || lim_d < CW'(2)) state_d = StSStart;
        else state_d = StPStart;
      end
      StSStart: begin
        rd_addr = '0;
        grp_d = '0;
        min_d = '0;
        state_d = (n_q == '0) ? StDone : StSFirst;
      end
      StSFirst: begin
        rd_addr = AW'(1);
        grp_d = CW'(1);
        min_d = x_hi;
        j_d = AW'(1);
        state_d = (n_q == CW'(1)) ? StDone : StSStep;
      end
      StSStep: begin
        rd_addr = j_q + AW'(1);
        if (min_s <= x_lo) begin
          grp_d = grp_q + CW'(1);
          min_d = x_hi;
        end else if (x_hi < min_s) begin
          min_d = x_hi;
        end
        if (CW'(j_q) == n_q - CW'(1)) state_d = StDone;
        else j_d = j_q + AW'(1);
      end
      StDone: begin
        mval_d = 1'b1;
        mcnt_d = (grp_ext > 32'(CountMax)) ? CountMax : grp_ext[CountW-1:0];
        movf_d = ovf_q;
        n_d = '0;
        ovf_d = 1'b0;
        state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      n_q     <= '0;
      ovf_q   <= 1'b0;
      mval_q  <= 1'b0;
      grp_q   <= '0;
      min_q   <= '0;
      lim_q   <= '0;
      j_q     <= '0;
      swp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ovf_q   <= ovf_d;
      mval_q  <= mval_d;
      grp_q   <= grp_d;
      min_q   <= min_d;
      lim_q   <= lim_d;
      j_q     <= j_d;
      swp_q   <= swp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    mcnt_q <= mcnt_d;
    movf_q <= movf_d;
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = OutDataW'(mcnt_q);
  assign m_axis_tuser  = movf_q;

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (n_q == CW'(MAX_INTERVALS))) else $error("overflow with free store");
  a_sort_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPStart) |-> (lim_q >= CW'(2))) else $error("sort pass too short");
  a_scan_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSStep || state_q == StSFirst) |-> !wr_en) else $error("write during scan");
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> !mval_q) else $error("result register overrun");
endmodule

[tb/interval_stabbing_count_tb.sv]
// Testbench for the interval stabbing counter: self-checking stream driver, monitor and predictor.
`timescale 1ns / 1ps
module interval_stabbing_count_tb;
  import isc_pkg::*;

  localparam int unsigned StoreDepth = 1024;

  typedef struct {
    bit                 carries;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    bit                 last;
    bit                 drain_first;  // hold this beat until no result is outstanding
  } span_beat_t;

  typedef struct {
    logic [CountW-1:0] points;
    bit                dropped;
  } stab_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // span_start[31:0], span_end[63:32]
  logic                s_axis_tuser;   // carries_interval
  logic                s_axis_tlast;   // last_of_set
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // point_count[10:0], zeros above
  logic                m_axis_tuser;   // overflowed

  span_beat_t   beat_queue[$];
  stab_result_t count_queue[$];
  longint       set_lo[$];
  longint       set_hi[$];
  bit           set_dropped;
  span_beat_t   drv_beat;
  int           send_idle_pct = 25;
  int           recv_idle_pct = 70;
  bit           hold_req = 1'b0;
  bit           hold_seen;
  int           hold_left;
  int           fail_count;
  int           sets_checked;
  int           beats_sent;

  interval_stabbing_count i_dut (.*);

  always #1 clk_i = ~clk_i;

  // Fewest stabbing points for the intervals of the current set.
  function automatic int count_points();
    longint lo[$];
    longint hi[$];
    longint klo, khi, min_end;
    int     j, groups;
    lo = set_lo;
    hi = set_hi;
    for (int i = 1; i < lo.size(); i++) begin
      klo = lo[i];
      khi = hi[i];
      j = i;
      while (j > 0 && (klo < lo[j-1] || (klo == lo[j-1] && khi < hi[j-1]))) begin
        lo[j] = lo[j-1];
        hi[j] = hi[j-1];
        j--;
      end
      lo[j] = klo;
      hi[j] = khi;
    end
    if (lo.size() == 0) return 0;
    groups = 1;
    min_end = hi[0];
    for (int i = 1; i < lo.size(); i++) begin
      if (min_end <= lo[i]) begin
        groups++;
        min_end = hi[i];
      end else if (hi[i] < min_end) begin
        min_end = hi[i];
      end
    end
    return groups;
  endfunction

  task automatic take_beat(input span_beat_t b);
    stab_result_t r;
    if (b.carries) begin
      if (set_lo.size() < StoreDepth) begin
        set_lo = {set_lo, longint'(b.lo)};
        set_hi = {set_hi, longint'(b.hi)};
      end else begin
        set_dropped = 1'b1;
      end
    end
    if (b.last) begin
      r.points  = CountW'(count_points());
      r.dropped = set_dropped;
      count_queue = {count_queue, r};
      set_lo.delete();
      set_hi.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Driver: advance on acceptance, idle at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_beat(drv_beat);
        beats_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (beat_queue.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            !(beat_queue[0].drain_first && count_queue.size() > 0)) begin
          drv_beat = beat_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {drv_beat.hi, drv_beat.lo};
          s_axis_tuser  <= drv_beat.carries;
          s_axis_tlast  <= drv_beat.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) hold_left--;
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    stab_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (count_queue.size() == 0) begin
        $error("result beat with nothing expected: point_count %0d", m_axis_tdata[CountW-1:0]);
        fail_count++;
      end else begin
        exp_r = count_queue.pop_front();
        sets_checked++;
        if (m_axis_tdata[CountW-1:0] !== exp_r.points) begin
          $error("point_count: expected %0d, got %0d", exp_r.points,
                 m_axis_tdata[CountW-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[OutDataW-1:CountW] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata[OutDataW-1:CountW]);
          fail_count++;
        end
        if (m_axis_tuser !== exp_r.dropped) begin
          $error("overflowed: expected %0d, got %0d", exp_r.dropped, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  task automatic push_beat(input bit carries, input logic signed [31:0] lo,
                           input logic signed [31:0] hi, input bit last,
                           input bit drain_first = 1'b0);
    span_beat_t b;
    b.carries = carries;
    b.lo = lo;
    b.hi = hi;
    b.last = last;
    b.drain_first = drain_first;
    beat_queue = {beat_queue, b};
  endtask

  function automatic logic [31:0] rand_coord(input int spread);
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                        : 32'h7fff_ffff - $urandom_range(3);
      default: return 32'($urandom_range(2 * spread) - spread);
    endcase
  endfunction

  // Random set: mostly well-formed intervals, some reversed, some empty beats.
  task automatic push_random_set(input int n, input bit drain_first);
    logic signed [31:0] lo, hi;
    int spread;
    spread = $urandom_range(1) ? 30 : 2000;
    for (int i = 0; i < n; i++) begin
      lo = rand_coord(spread);
      hi = ($urandom_range(9) == 0) ? rand_coord(spread)
                                    : lo + 32'($urandom_range(spread / 3));
      if (hi < lo && $urandom_range(3) != 0) hi = 32'h7fff_ffff;
      if ($urandom_range(11) == 0)
        push_beat(1'b0, $urandom(), $urandom(), 1'b0, drain_first && i == 0);
      push_beat(1'b1, lo, hi, (i == n - 1) && $urandom_range(1),
                drain_first && i == 0);
    end
    if (n == 0 || !beat_queue[$].last) push_beat(1'b0, $urandom(), $urandom(), 1'b1);
  endtask

  initial begin
    int total;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    set_dropped = 1'b0;
    fail_count = 0;
    sets_checked = 0;
    beats_sent = 0;

    // Directed: empty set, touching ends, extremes, reversed, duplicates.
    push_beat(1'b0, 32'h1234_5678, 32'h9abc_def0, 1'b1);
    push_beat(1'b1, 0, 5, 1'b0);
    push_beat(1'b1, 5, 9, 1'b1);
    push_beat(1'b1, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    push_beat(1'b0, '1, '1, 1'b0);
    push_beat(1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    push_beat(1'b1, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    push_beat(1'b1, 10, -10, 1'b0);
    push_beat(1'b1, 3, 4, 1'b0);
    push_beat(1'b1, 3, 4, 1'b0);
    push_beat(1'b1, -20, -1, 1'b1);
    push_beat(1'b1, 1, 8, 1'b0);
    push_beat(1'b1, 2, 3, 1'b0);
    push_beat(1'b1, 4, 6, 1'b0);
    push_beat(1'b1, 1, 2, 1'b1);
    push_beat(1'b1, -1, 0, 1'b1);

    for (int k = 0; k < 12; k++) push_random_set($urandom_range(12), k % 6 == 0);

    // Full store plus dropped beats; sorted input keeps the sort to one pass.
    for (int i = 0; i < StoreDepth + 3; i++)
      push_beat(1'b1, 32'(2 * i - 1000), 32'(2 * i - 999), i == StoreDepth + 2, i == 0);
    push_beat(1'b1, 7, 8, 1'b1);  // drop flag must clear for the next set

    for (int k = 0; k < 24; k++) push_random_set($urandom_range(14), k % 8 == 0);
    total = beat_queue.size();

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beat_queue.size() > total * 2 / 3) @(posedge clk_i);
    send_idle_pct = 70;
    recv_idle_pct = 25;
    while (beat_queue.size() > total / 3) @(posedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;

    while (beat_queue.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (count_queue.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d input beats and %0d sets, incl. a store overflow and long stalls",
             beats_sent, sets_checked);
    if (fail_count == 0 && count_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
rtl/isc_pkg.sv
rtl/isc_ram.sv
rtl/interval_stabbing_count.sv
tb/interval_stabbing_count_tb.sv
